// File: src/sfcs_pkg.sv
package sfcs_pkg;

   localparam int PAGE_BYTES = 256;
   localparam int IDX_W = $clog2(PAGE_BYTES + 4);
   localparam logic [IDX_W-1:0] ADDR_BYTES = IDX_W'(3);
   localparam logic [IDX_W-1:0] LEN_RDSR = IDX_W'(1);
   localparam logic [IDX_W-1:0] LEN_PAGE = IDX_W'(PAGE_BYTES + 3);
   localparam logic [IDX_W-1:0] LEN_ERASE = IDX_W'(3);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_RDSR = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_PROG = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;

   localparam logic [7:0] OPC_RDSR = 8'h05;
   localparam logic [7:0] OPC_READ = 8'h03;
   localparam logic [7:0] OPC_PROG = 8'h02;
   localparam logic [7:0] OPC_WREN = 8'h06;
   localparam logic [7:0] OPC_ERASE = 8'hd8;
   localparam logic [7:0] WIP_MASK = 8'h01;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic       byte_done;
      logic [1:0] op;
      logic [7:0] opcode;
      logic       needs_wren;
      logic [15:0] page;
      logic [7:0] host_byte;
      logic [7:0] miso_byte;
   } item_type;

   typedef struct packed {
      logic       mosi_valid;
      logic [7:0] mosi_byte;
      logic       frame_last;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       op_done;
      logic       rejected;
   } result_type;

   function automatic logic [7:0] opcode_of(input logic [1:0] op);
      logic [7:0] opc;
      case (op)
         OP_RDSR: opc = OPC_RDSR;
         OP_READ: opc = OPC_READ;
         OP_PROG: opc = OPC_PROG;
         default: opc = OPC_ERASE;
      endcase
      return opc;
   endfunction

   function automatic logic [IDX_W-1:0] frame_len(input logic [1:0] op);
      logic [IDX_W-1:0] len;
      case (op)
         OP_RDSR: len = LEN_RDSR;
         OP_READ: len = LEN_PAGE;
         OP_PROG: len = LEN_PAGE;
         default: len = LEN_ERASE;
      endcase
      return len;
   endfunction

endpackage

// File: src/sfcs_front.sv
module sfcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_cmd,
   input  logic [sfcs_pkg::REQ_DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output sfcs_pkg::item_type out_item
);

   sfcs_pkg::item_type queue_ff [sfcs_pkg::QUEUE_DEPTH];
   logic [sfcs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sfcs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sfcs_pkg::QCNT_W-1:0] count_ff, count_in;
   sfcs_pkg::item_type item;
   logic push, pop;

   // classify the incoming request
   always_comb begin
      item.byte_done  = in_cmd;
      item.op         = in_data[1:0];
      item.page       = in_data[17:2];
      item.host_byte  = in_data[25:18];
      item.miso_byte  = in_data[33:26];
      item.opcode     = sfcs_pkg::opcode_of(in_data[1:0]);
      item.needs_wren = in_data[1];
   end

   assign in_ready  = (count_ff != sfcs_pkg::QCNT_W'(sfcs_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = queue_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sfcs_pkg::QPTR_W'(sfcs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sfcs_pkg::QPTR_W'(sfcs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: src/sfcs_back.sv
module sfcs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sfcs_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output sfcs_pkg::result_type out_result
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_WREN      = 3'd1;
   localparam logic [2:0] PH_FRAME     = 3'd2;
   localparam logic [2:0] PH_POLL_OP   = 3'd3;
   localparam logic [2:0] PH_POLL_DATA = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [sfcs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [1:0] op_ff, op_in;
   logic [15:0] page_ff, page_in;
   logic out_valid_ff, out_valid_in;
   sfcs_pkg::result_type res_ff, res_in;
   logic [sfcs_pkg::IDX_W-1:0] len, skip;
   logic fire;

   assign in_ready   = !out_valid_ff || out_ready;
   assign fire       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = res_ff;
   assign len        = sfcs_pkg::frame_len(op_ff);
   assign skip       = (op_ff == sfcs_pkg::OP_READ) ? sfcs_pkg::ADDR_BYTES : '0;

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      page_in      = page_ff;
      res_in       = '0;
      out_valid_in = out_valid_ff && !out_ready;
      if (fire) begin
         out_valid_in = 1'b1;
         if (!in_item.byte_done) begin
            if (phase_ff != PH_IDLE) begin
               res_in.rejected = 1'b1;
            end else begin
               op_in             = in_item.op;
               page_in           = in_item.page;
               idx_in            = '0;
               res_in.mosi_valid = 1'b1;
               if (in_item.needs_wren) begin
                  res_in.mosi_byte  = sfcs_pkg::OPC_WREN;
                  res_in.frame_last = 1'b1;
                  phase_in          = PH_WREN;
               end else begin
                  res_in.mosi_byte = in_item.opcode;
                  phase_in         = PH_FRAME;
               end
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_WREN: begin
                  res_in.mosi_valid = 1'b1;
                  res_in.mosi_byte  = sfcs_pkg::opcode_of(op_ff);
                  idx_in            = '0;
                  phase_in          = PH_FRAME;
               end
               PH_FRAME: begin
                  if (!op_ff[1] && idx_ff > skip) begin
                     res_in.rx_valid = 1'b1;
                     res_in.rx_byte  = in_item.miso_byte;
                  end
                  if (idx_ff < len) begin
                     res_in.mosi_valid = 1'b1;
                     if (idx_ff == sfcs_pkg::IDX_W'(0) && op_ff != sfcs_pkg::OP_RDSR) begin
                        res_in.mosi_byte = page_ff[15:8];
                     end else if (idx_ff == sfcs_pkg::IDX_W'(1) &&
                                  op_ff != sfcs_pkg::OP_RDSR) begin
                        res_in.mosi_byte = page_ff[7:0];
                     end else if (idx_ff >= sfcs_pkg::ADDR_BYTES &&
                                  op_ff == sfcs_pkg::OP_PROG) begin
                        res_in.mosi_byte = in_item.host_byte;
                     end
                     res_in.frame_last = (idx_ff == len - 1'b1);
                     idx_in            = idx_ff + 1'b1;
                  end else if (op_ff[1]) begin
                     res_in.mosi_valid = 1'b1;
                     res_in.mosi_byte  = sfcs_pkg::OPC_RDSR;
                     phase_in          = PH_POLL_OP;
                  end else begin
                     res_in.op_done = 1'b1;
                     phase_in       = PH_IDLE;
                  end
               end
               PH_POLL_OP: begin
                  res_in.mosi_valid = 1'b1;
                  res_in.frame_last = 1'b1;
                  phase_in          = PH_POLL_DATA;
               end
               PH_POLL_DATA: begin
                  if ((in_item.miso_byte & sfcs_pkg::WIP_MASK) != '0) begin
                     res_in.mosi_valid = 1'b1;
                     res_in.mosi_byte  = sfcs_pkg::OPC_RDSR;
                     phase_in          = PH_POLL_OP;
                  end else begin
                     res_in.op_done = 1'b1;
                     phase_in       = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         idx_ff       <= '0;
         op_ff        <= '0;
         page_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         op_ff        <= op_in;
         page_ff      <= page_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

endmodule

// File: src/spi_flash_command_sequencer_unit.sv
// spi nor flash command sequencer
// req channel: tuser[0] is the kind, 0 = start an operation, 1 = previous byte
// exchange finished. tdata holds op, page, host_byte and miso_byte.
// op: 0 read status, 1 read page, 2 program page, 3 erase sector.
// rsp channel: exactly one response per request. tdata holds the next mosi
// byte with its valid flag, a received byte for the host with its valid flag,
// op_done and rejected; tlast marks the byte after which chip select rises.
// program and erase run write enable, the main frame, then status polls until
// the write-in-progress bit clears. a start request while busy is rejected.
// a response passes through the classify queue and then the sequencer's
// output register.
// throughput: one request per cycle while rsp_tready stays high; each request
// is a sequencer step that updates phase and byte index.
// when rsp_tready is low the response holds and the 2-entry queue keeps
// taking requests until full, then req_tready drops.
// reset clears the queue and returns the sequencer to idle; no clearing pass.
module spi_flash_command_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], page[17:2], host_byte[25:18], miso_byte[33:26], zero fill
   input  logic [sfcs_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mosi_valid[0], mosi_byte[8:1], rx_valid[9], rx_byte[17:10],
   // op_done[18], rejected[19], zero fill
   output logic [sfcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast
);

   sfcs_pkg::item_type   q_item;
   sfcs_pkg::result_type result;
   logic q_valid, q_ready;

   sfcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser[0]),
      .in_data   (req_tdata),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   sfcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {4'b0, result.rejected, result.op_done, result.rx_byte,
                       result.rx_valid, result.mosi_byte, result.mosi_valid};
   assign rsp_tlast = result.frame_last;

   a_last_has_mosi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0])
      else $error("frame end without a mosi byte");

   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> rsp_tdata[18:0] == '0 && !rsp_tlast)
      else $error("rejected response carries other fields");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> !rsp_tdata[0])
      else $error("op_done together with a new mosi byte");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

// File: dv/spi_flash_command_sequencer_unit_test.sv
`timescale 1ns / 100ps

module spi_flash_command_sequencer_unit_test;
   import sfcs_pkg::*;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE_DONE = 1'b1;
   localparam int RANDOM_ITEMS = 1550;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WREN,
      SEQ_FRAME,
      SEQ_POLL_OP,
      SEQ_POLL_DATA
   } seq_phase_type;

   typedef struct {
      logic        kind;
      logic [1:0]  op;
      logic [15:0] page;
      logic [7:0]  host_byte;
      logic [7:0]  miso_byte;
      bit          typed_in;
      result_type  want;
   } flash_request_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   seq_phase_type     seq_phase;
   int                byte_idx;
   logic [1:0]        cur_op;
   logic [15:0]       page_q;
   result_type        expected_exchanges[$];
   flash_request_type directed_plan[$];
   int                mismatches;
   int                stall_cycles;
   int                counted_items;
   bit                no_gaps;

   spi_flash_command_sequencer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] instr_for(input logic [1:0] op);
      logic [7:0] opc;
      case (op)
         OP_RDSR: opc = OPC_RDSR;
         OP_READ: opc = OPC_READ;
         OP_PROG: opc = OPC_PROG;
         default: opc = OPC_ERASE;
      endcase
      return opc;
   endfunction

   // one sequencer step, updates the predicted state
   function automatic result_type flash_exchange(input flash_request_type rq);
      result_type r;
      int         len;
      int         skip;
      r = '0;
      if (rq.kind == KIND_START) begin
         if (seq_phase != SEQ_IDLE) begin
            r.rejected = 1'b1;
         end else begin
            cur_op = rq.op;
            page_q = rq.page;
            byte_idx = 0;
            r.mosi_valid = 1'b1;
            if (rq.op >= OP_PROG) begin
               r.mosi_byte = OPC_WREN;
               r.frame_last = 1'b1;
               seq_phase = SEQ_WREN;
            end else begin
               r.mosi_byte = instr_for(rq.op);
               seq_phase = SEQ_FRAME;
            end
         end
      end else begin
         case (seq_phase)
            SEQ_WREN: begin
               r.mosi_valid = 1'b1;
               r.mosi_byte = instr_for(cur_op);
               byte_idx = 0;
               seq_phase = SEQ_FRAME;
            end
            SEQ_FRAME: begin
               len = (cur_op == OP_RDSR) ? 1 : (cur_op == OP_ERASE) ? 3 : PAGE_BYTES + 3;
               skip = (cur_op == OP_READ) ? 3 : 0;
               if (cur_op <= OP_READ && byte_idx > 0 && byte_idx - 1 >= skip) begin
                  r.rx_valid = 1'b1;
                  r.rx_byte = rq.miso_byte;
               end
               if (byte_idx < len) begin
                  r.mosi_valid = 1'b1;
                  if (cur_op != OP_RDSR && byte_idx == 0)
                     r.mosi_byte = page_q[15:8];
                  else if (cur_op != OP_RDSR && byte_idx == 1)
                     r.mosi_byte = page_q[7:0];
                  else if (cur_op == OP_PROG && byte_idx >= 3)
                     r.mosi_byte = rq.host_byte;
                  r.frame_last = (byte_idx + 1 == len);
                  byte_idx++;
               end else if (cur_op >= OP_PROG) begin
                  r.mosi_valid = 1'b1;
                  r.mosi_byte = OPC_RDSR;
                  seq_phase = SEQ_POLL_OP;
               end else begin
                  r.op_done = 1'b1;
                  seq_phase = SEQ_IDLE;
               end
            end
            SEQ_POLL_OP: begin
               r.mosi_valid = 1'b1;
               r.frame_last = 1'b1;
               seq_phase = SEQ_POLL_DATA;
            end
            SEQ_POLL_DATA: begin
               if ((rq.miso_byte & WIP_MASK) != 8'h00) begin
                  r.mosi_valid = 1'b1;
                  r.mosi_byte = OPC_RDSR;
                  seq_phase = SEQ_POLL_OP;
               end else begin
                  r.op_done = 1'b1;
                  seq_phase = SEQ_IDLE;
               end
            end
            default: seq_phase = SEQ_IDLE;
         endcase
      end
      return r;
   endfunction

   function automatic void add_row(input logic kind, input logic [1:0] op,
                                   input logic [15:0] page, input logic [7:0] host_byte,
                                   input logic [7:0] miso_byte, input bit typed_in,
                                   input logic mv, input logic [7:0] mb, input logic fl,
                                   input logic rv, input logic [7:0] rb, input logic dn,
                                   input logic rj);
      flash_request_type rq;
      rq.kind = kind;
      rq.op = op;
      rq.page = page;
      rq.host_byte = host_byte;
      rq.miso_byte = miso_byte;
      rq.typed_in = typed_in;
      rq.want = '{mosi_valid: mv, mosi_byte: mb, frame_last: fl, rx_valid: rv,
                  rx_byte: rb, op_done: dn, rejected: rj};
      directed_plan.push_back(rq);
   endfunction

   task automatic send_request(input flash_request_type rq);
      int         gap;
      result_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.kind;
      req_tdata <= {6'b0, rq.miso_byte, rq.host_byte, rq.page, rq.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!(rq.kind == KIND_BYTE_DONE && seq_phase == SEQ_IDLE))
         counted_items++;
      predicted = flash_exchange(rq);
      expected_exchanges.push_back(rq.typed_in ? rq.want : predicted);
      if ($urandom_range(0, 63) == 0)
         no_gaps = ~no_gaps;
   endtask

   function automatic flash_request_type random_request();
      flash_request_type rq;
      int                pick;
      rq.page = 16'($urandom);
      rq.host_byte = 8'($urandom);
      rq.miso_byte = 8'($urandom);
      rq.typed_in = 1'b0;
      rq.want = '0;
      pick = $urandom_range(0, 99);
      rq.op = (pick < 40) ? OP_RDSR : (pick < 47) ? OP_READ : (pick < 54) ? OP_PROG : OP_ERASE;
      if (seq_phase == SEQ_IDLE)
         rq.kind = ($urandom_range(0, 99) < 88) ? KIND_START : KIND_BYTE_DONE;
      else
         rq.kind = ($urandom_range(0, 99) < 93) ? KIND_BYTE_DONE : KIND_START;
      if (seq_phase == SEQ_POLL_DATA)
         rq.miso_byte[0] = ($urandom_range(0, 3) == 0);
      return rq;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mosi_valid = rsp_tdata[0];
         got.mosi_byte = rsp_tdata[8:1];
         got.frame_last = rsp_tlast;
         got.rx_valid = rsp_tdata[9];
         got.rx_byte = rsp_tdata[17:10];
         got.op_done = rsp_tdata[18];
         got.rejected = rsp_tdata[19];
         if (expected_exchanges.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_exchanges.pop_front();
            check_field("mosi_valid", 8'(want.mosi_valid), 8'(got.mosi_valid));
            check_field("mosi_byte", want.mosi_byte, got.mosi_byte);
            check_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
            check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            check_field("rx_byte", want.rx_byte, got.rx_byte);
            check_field("op_done", 8'(want.op_done), 8'(got.op_done));
            check_field("rejected", 8'(want.rejected), 8'(got.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // response side backpressure
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      seq_phase = SEQ_IDLE;
      byte_idx = 0;
      cur_op = OP_RDSR;
      page_q = '0;
      mismatches = 0;
      stall_cycles = 0;
      counted_items = 0;
      no_gaps = 1'b0;

      // idle byte done, status read, busy reject, erase with one wip poll
      add_row(KIND_BYTE_DONE, OP_ERASE, 16'hffff, 8'hff, 8'hff, 1, 0, 8'h00, 0, 0, 8'h00, 0, 0);
      add_row(KIND_START, OP_RDSR, 16'hffff, 8'hff, 8'hff, 1, 1, OPC_RDSR, 0, 0, 8'h00, 0, 0);
      add_row(KIND_START, OP_ERASE, 16'h0000, 8'h00, 8'h00, 1, 0, 8'h00, 0, 0, 8'h00, 0, 1);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'ha5, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_START, OP_ERASE, 16'hffff, 8'hff, 8'hff, 1, 1, OPC_WREN, 1, 0, 8'h00, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'hfe, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'h00, 1, 0, 8'h00, 0, 0, 8'h00, 0, 0);
      // page read with a busy program reject, left running into the random part
      add_row(KIND_START, OP_READ, 16'h0000, 8'h00, 8'h00, 1, 1, OPC_READ, 0, 0, 8'h00, 0, 0);
      add_row(KIND_START, OP_PROG, 16'hffff, 8'hff, 8'hff, 1, 0, 8'h00, 0, 0, 8'h00, 0, 1);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_BYTE_DONE, OP_RDSR, 16'h0000, 8'h00, 8'h5a, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send_request(directed_plan[i]);
      while (counted_items < RANDOM_ITEMS)
         send_request(random_request());
      req_tvalid <= 1'b0;

      while (expected_exchanges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
